// File: design/rdc_pkg.sv
// Shared constants and types for the radix digit converter.
package rdc_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int POS_W     = 3;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  // Slot limits and defaults
  localparam int MAX_SLOTS          = 8;
  localparam int DEFAULT_NUM_DIGITS = 8;

  // Radix limits and reset value
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 16;
  localparam int RADIX_RESET = 16;

  // Control states
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Status returned by the serial divider
  typedef struct packed {
    logic               done;
    logic               nonzero;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

// File: design/rdc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
module rdc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rdc_pkg::VALUE_W-1:0]   dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]   divisor,
  output logic [rdc_pkg::VALUE_W-1:0]   quotient,
  output rdc_pkg::div_res_t             res
);
  import rdc_pkg::*;

  logic                 active;
  logic                 done;
  logic [BIT_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]   dvd;
  logic [DIGIT_W-1:0]   rem;
  logic                 qnz;

  logic [RADIX_W-1:0]   trial;
  logic [RADIX_W-1:0]   diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem, dvd[VALUE_W-1]};
    diff  = trial - divisor;
    ge    = (trial >= divisor);
  end

  // Control: count VALUE_W steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (cnt == BIT_CNT_W'(VALUE_W - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      qnz <= 1'b0;
    end else if (active) begin
      dvd <= {dvd[VALUE_W-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      qnz <= qnz | ge;
    end
  end

  assign quotient    = dvd;
  assign res.done    = done;
  assign res.nonzero = qnz;
  assign res.rem     = rem;

  // Checks
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !active)
    else $error("divider done while still active");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !done)
    else $error("divider done held longer than one cycle");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < divisor))
    else $error("remainder not below divisor");

endmodule

// File: design/radix_digit_converter_top.sv
// Top level of the radix digit converter: control, config register, result registers.
//
// Usage: write the radix on the cfg channel (cfg_valid/cfg_ready, cfg_ready is
// always high); values below 2 store as 2, above 16 as 16. Reset sets radix 16.
// Present value with start; the item is taken at an edge with start high and
// busy low. Digits come out least significant first, one per result, each on
// the result ports for one cycle while result_strobe is high. The first digit
// carries position NUM_DIGITS-1 (slot count clamped to 1..8) and each later
// digit one position lower. last marks the final result; truncated is set on
// it when digits remain after slot 0 was used. A zero value yields one result
// with no_digits set, in the cycle after it is taken.
// Timing: each digit comes from a bit-serial divider, one quotient bit per
// cycle, and the block takes no new item while busy; it takes the next item
// in the cycle its last result is shown.
// Reset returns the control to idle and the radix to 16; no result is pending
// afterwards.
// The receiver cannot stall: results are never held back.
module radix_digit_converter_top #(
  parameter int NUM_DIGITS = rdc_pkg::DEFAULT_NUM_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rdc_pkg::VALUE_W-1:0] value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
  output logic                        result_strobe,
  output logic [rdc_pkg::POS_W-1:0]   position,
  output logic [rdc_pkg::DIGIT_W-1:0] digit,
  output logic                        no_digits,
  output logic                        truncated,
  output logic                        last
);
  import rdc_pkg::*;

  localparam int SLOTS = (NUM_DIGITS < 1) ? 1 :
                         ((NUM_DIGITS > MAX_SLOTS) ? MAX_SLOTS : NUM_DIGITS);

  state_t             state, state_next;
  logic [RADIX_W-1:0] radix;
  logic [POS_W-1:0]   pos;

  logic               accept;
  logic               value_zero;
  logic               digit_fin;

  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  logic [VALUE_W-1:0] div_q;
  div_res_t           div_res;

  logic               emit;
  logic               emit_zero;

  assign accept     = start && !busy;
  assign value_zero = (value == '0);
  assign digit_fin  = !div_res.nonzero || (pos == '0);
  assign cfg_ready  = 1'b1;

  // Radix register with clamping on write
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_W'(RADIX_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < RADIX_W'(RADIX_MIN)) begin
        radix <= RADIX_W'(RADIX_MIN);
      end else if (cfg_data > RADIX_W'(RADIX_MAX)) begin
        radix <= RADIX_W'(RADIX_MAX);
      end else begin
        radix <= cfg_data;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !value_zero) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done && digit_fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy         = (state != ST_IDLE);
    div_start    = 1'b0;
    div_dividend = value;
    emit         = 1'b0;
    emit_zero    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          div_start = !value_zero;
          emit_zero = value_zero;
        end
      end
      ST_DIV: begin
        div_dividend = div_q;
        if (div_res.done) begin
          emit      = 1'b1;
          div_start = !digit_fin;
        end
      end
      default: ;
    endcase
  end

  // State and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        pos <= POS_W'(SLOTS - 1);
      end else if (emit) begin
        pos <= pos - 1'b1;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit || emit_zero;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit_zero) begin
      position  <= '0;
      digit     <= '0;
      no_digits <= 1'b1;
      truncated <= 1'b0;
      last      <= 1'b1;
    end else if (emit) begin
      position  <= pos;
      digit     <= div_res.rem;
      no_digits <= 1'b0;
      truncated <= div_res.nonzero && (pos == '0);
      last      <= digit_fin;
    end
  end

  rdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix),
    .quotient (div_q),
    .res      (div_res)
  );

  // Checks
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe && no_digits |-> last && position == '0 && digit == '0)
    else $error("zero-input result malformed");
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && truncated |-> last && !no_digits)
    else $error("truncated flag on a non-final result");
  a_more_digits: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("block idle while digits remain");
  a_nonzero_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !value_zero |=> busy)
    else $error("nonzero item did not start conversion");
  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    radix >= RADIX_W'(RADIX_MIN) && radix <= RADIX_W'(RADIX_MAX))
    else $error("radix register out of range");

endmodule

// File: tb/rdc_digit_checker.sv
// Checker for the radix digit converter: predicts digit results and compares them.
module rdc_digit_checker #(
  parameter int NUM_DIGITS = rdc_pkg::DEFAULT_NUM_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rdc_pkg::VALUE_W-1:0] value,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
  input  logic                        result_strobe,
  input  logic [rdc_pkg::POS_W-1:0]   position,
  input  logic [rdc_pkg::DIGIT_W-1:0] digit,
  input  logic                        no_digits,
  input  logic                        truncated,
  input  logic                        last,
  output int                          pending,
  output int                          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] digit;
    logic               no_digits;
    logic               truncated;
    logic               last;
  } digit_rec_t;

  // Slot count seen on the result ports, clamped to what 3 bits can tag
  localparam int SLOTS = (NUM_DIGITS < 1) ? 1 :
                         ((NUM_DIGITS > MAX_SLOTS) ? MAX_SLOTS : NUM_DIGITS);

  digit_rec_t        expected_digits[$];
  logic [RADIX_W-1:0] base;
  digit_rec_t        want;
  digit_rec_t        got;

  // Clamp a written radix into 2..16
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_W'(RADIX_MIN);
    if (r > RADIX_MAX) return RADIX_W'(RADIX_MAX);
    return r;
  endfunction

  // Queue the digit results one value produces in the current base
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] b;
    logic [POS_W-1:0]   pos;
    int                 used;
    digit_rec_t         rec;
    b   = VALUE_W'(base);
    pos = POS_W'(SLOTS - 1);
    if (v == '0) begin
      rec = '{position: '0, digit: '0, no_digits: 1'b1, truncated: 1'b0, last: 1'b1};
      expected_digits.push_back(rec);
    end else begin
      q    = v;
      used = 0;
      while (q != '0 && used < SLOTS) begin
        rec.position  = pos;
        rec.digit     = DIGIT_W'(q % b);
        rec.no_digits = 1'b0;
        q             = q / b;
        used++;
        pos           = pos - 1'b1;
        // last digit: quotient exhausted or out of slots
        rec.last      = (q == '0) || (used == SLOTS);
        rec.truncated = rec.last && (q != '0);
        expected_digits.push_back(rec);
      end
    end
  endtask

  // Watch config, results and accepted items at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      base = RADIX_W'(RADIX_RESET);
      expected_digits.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        base = clamp_radix(cfg_data);

      if (result_strobe) begin
        got = '{position, digit, no_digits, truncated, last};
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result pos %0d digit %0d nd %b tr %b last %b",
                     $realtime, position, digit, no_digits, truncated, last);
        end else begin
          want = expected_digits.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp pos %0d digit %0d nd %b tr %b last %b / got pos %0d digit %0d nd %b tr %b last %b",
                       $realtime, want.position, want.digit, want.no_digits,
                       want.truncated, want.last, position, digit, no_digits,
                       truncated, last);
          end
        end
      end

      if (start && !busy)
        predict_digits(value);
    end
    pending = expected_digits.size();
  end

endmodule

// File: tb/radix_digit_converter_top_tb.sv
// Testbench top for the radix digit converter: stimulus, watchdog and verdict.
module radix_digit_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data;
  logic               result_strobe;
  logic [POS_W-1:0]   position;
  logic [DIGIT_W-1:0] digit;
  logic               no_digits;
  logic               truncated;
  logic               last;

  int pending;
  int mismatches;
  int quiet_cycles;
  int cur_base;

  radix_digit_converter_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .position(position), .digit(digit),
    .no_digits(no_digits), .truncated(truncated), .last(last)
  );

  rdc_digit_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .position(position), .digit(digit),
    .no_digits(no_digits), .truncated(truncated), .last(last),
    .pending(pending), .mismatches(mismatches)
  );

  always #4 clk = ~clk;

  // Watchdog: run is stuck if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Wait until the block is idle and every digit has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (busy || pending != 0) @(negedge clk);
  endtask

  // Write the radix register once the block is idle
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain();
    cfg_data  <= r;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_base  = (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : int'(r));
  endtask

  // Hand one item to the block; hold_off 0 = back to back, 1 = gap,
  // 2 = wait for idle then gap
  task automatic send_value(input logic [VALUE_W-1:0] v, input int hold_off);
    if (hold_off != 0) begin
      start <= 1'b0;
      @(negedge clk);
      if (hold_off == 2)
        while (busy) @(negedge clk);
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Values at a power of the current base, or one below it
  function automatic logic [VALUE_W-1:0] base_power_value();
    longint p;
    int     k;
    p = 1;
    k = $urandom_range(1, MAX_SLOTS);
    repeat (k) p = p * cur_base;
    return VALUE_W'(p - $urandom_range(0, 1));
  endfunction

  // Random value: zero, full width, shortened, or near a digit boundary
  function automatic logic [VALUE_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind <= 3) return $urandom;
    if (kind <= 7) return $urandom >> $urandom_range(1, 31);
    return base_power_value();
  endfunction

  initial begin
    int idle_on;
    int hold_off;
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    cur_base  = RADIX_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset radix 16, full width and a single digit
    send_value(32'h0000_0000, 0);
    send_value(32'h0000_0001, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'h0123_4567, 2);

    // Radix write below range clamps to 2; exactly eight bits vs truncated
    write_radix(5'd0);
    send_value(32'h0000_00FF, 0);
    send_value(32'h0000_0100, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h0000_0001, 0);
    send_value(32'h0000_0000, 0);

    // Radix write above range clamps to 16, below range to 2
    write_radix(5'd31);
    send_value(32'hFEDC_BA98, 0);
    write_radix(5'd1);
    send_value(32'h0000_0002, 0);
    write_radix(5'd17);
    send_value(32'h0000_000F, 0);

    // Decimal: exactly eight digits, nine digits, short, zero; then radix 3 and 16
    write_radix(5'd10);
    send_value(32'd99999999, 0);
    send_value(32'd100000000, 0);
    send_value(32'd12345, 1);
    send_value(32'h0000_0000, 0);
    write_radix(5'd3);
    send_value(32'hFFFF_FFFF, 0);
    write_radix(5'd16);
    send_value(32'h0000_0010, 0);

    // Random phases, new radix each phase; last two phases run without gaps
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_radix(5'd0);
        1:       write_radix(5'd31);
        2:       write_radix(5'd2);
        3:       write_radix(5'd16);
        default: write_radix(RADIX_W'($urandom_range(0, 31)));
      endcase
      idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        hold_off = 0;
        if (idle_on && $urandom_range(0, 1) == 1)
          hold_off = $urandom_range(1, 2);
        send_value(pick_value(), hold_off);
      end
    end

    // Let the last digits arrive, then watch for stray results
    drain();
    repeat (300) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
